// ===== rtl/core/soc_pkg.sv =====
// shared constants, codes and transaction types of the substring occurrence counter
// no dependencies; used by every file in rtl/core
package soc_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned CountBits  = 16;
  localparam int unsigned MatchBits  = 16;
  localparam int unsigned LenBits    = $clog2(MaxPattern + 1);
  localparam int unsigned IdxBits    = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int unsigned WideBits   = (CountBits > MatchBits) ? CountBits : MatchBits;

  localparam logic [1:0] CmdStart  = 2'd0;
  localparam logic [1:0] CmdAppend = 2'd1;
  localparam logic [1:0] CmdText   = 2'd2;
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusNoPattern = 2'd1;
  localparam logic [1:0] StatusShort     = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [MatchBits-1:0] match_count;
    logic [1:0]           status;
  } out_item_t;

  typedef struct packed {
    logic       clear;
    logic       shift;
    logic       wr_en;
    logic [7:0] char_byte;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/soc_cell.sv =====
// one compare cell: holds one pattern byte and the prefix-match flag up to it
// depends on soc_pkg
module soc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  soc_pkg::cell_ctrl_t ctrl_i,
  input  logic               prev_match_i,
  output logic               match_o,
  output logic               hit_o
);

  logic [7:0] pat_q;
  logic       match_q;
  logic       match_d;

  assign hit_o = prev_match_i && (pat_q == ctrl_i.char_byte);

  always_comb begin
    match_d = match_q;
    if (ctrl_i.clear) begin
      match_d = 1'b0;
    end else if (ctrl_i.shift) begin
      match_d = hit_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      pat_q <= ctrl_i.char_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

// ===== rtl/core/substring_occurrence_counter_core.sv =====
// top level of the substring occurrence counter: command decode, cell chain, result register
// depends on soc_pkg and soc_cell
//
// usage:
// - input channel in_valid_i / in_ready_o / in_data_i carries one command per transaction:
//   start a pattern with a byte, append a pattern byte, or a text byte with end_of_text
// - output channel out_valid_o / out_ready_i / out_data_o carries one result per text,
//   sent for the text byte marked end_of_text: match count and status
// - each cell of the chain holds one pattern byte and the flag that the pattern prefix
//   ending at that byte matches the text ending at the newest byte; flags move one cell
//   per text byte
// - throughput is one transaction per cycle while in_ready_o is high; a result appears
//   in out_data_o the cycle after its last text byte is accepted
// - in_ready_o drops only while a result is held and out_ready_i is low; a stalled
//   result holds, and input is taken again in the cycle the result is taken
// - a pattern command abandons any text in progress and sends no result
// - reset empties the pattern, the count and the result register; pattern bytes
//   themselves are not cleared and need no clearing pass
module substring_occurrence_counter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  soc_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output soc_pkg::out_item_t  out_data_o
);

  localparam int unsigned Max = soc_pkg::MaxPattern;
  localparam int unsigned LB  = soc_pkg::LenBits;
  localparam int unsigned IB  = soc_pkg::IdxBits;
  localparam int unsigned CB  = soc_pkg::CountBits;
  localparam int unsigned WB  = soc_pkg::WideBits;
  localparam int unsigned MB  = soc_pkg::MatchBits;

  logic [LB-1:0]       len_q, len_d;
  logic [LB-1:0]       seen_q, seen_d;
  logic [CB-1:0]       count_q, count_d;
  logic                out_valid_q, out_valid_d;
  soc_pkg::out_item_t  out_data_q, out_data_d;

  soc_pkg::cell_ctrl_t ctrl [Max];
  logic [Max-1:0]      flag;
  logic [Max-1:0]      hit;

  logic                accept;
  logic                is_text;
  logic                is_pat;
  logic                last;
  logic                wr_any;
  logic [IB-1:0]       wr_idx;
  logic [IB-1:0]       sel_idx;
  logic [LB-1:0]       len_m1;
  logic                match;
  logic [LB-1:0]       seen_inc;
  logic [CB-1:0]       count_inc;
  logic [WB-1:0]       count_wide;
  logic [MB-1:0]       count_out;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_text    = accept && (in_data_i.cmd == soc_pkg::CmdText);
  assign is_pat     = accept && ((in_data_i.cmd == soc_pkg::CmdStart) ||
                                 (in_data_i.cmd == soc_pkg::CmdAppend));
  assign last       = is_text && in_data_i.end_of_text;

  assign len_m1  = len_q - LB'(1);
  assign sel_idx = len_m1[IB-1:0];
  assign match   = is_text && (len_q != '0) && hit[sel_idx];

  assign seen_inc  = seen_q + LB'(seen_q != LB'(Max));
  assign count_inc = count_q + CB'(match && (count_q != {CB{1'b1}}));
  assign count_wide = WB'(count_inc);
  assign count_out  = (count_wide > WB'({MB{1'b1}})) ? {MB{1'b1}} : count_wide[MB-1:0];

  always_comb begin
    wr_any = 1'b0;
    wr_idx = '0;
    len_d  = len_q;
    if (accept && (in_data_i.cmd == soc_pkg::CmdStart)) begin
      wr_any = 1'b1;
      len_d  = LB'(1);
    end else if (accept && (in_data_i.cmd == soc_pkg::CmdAppend) && (len_q != LB'(Max))) begin
      wr_any = 1'b1;
      wr_idx = len_q[IB-1:0];
      len_d  = len_q + LB'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < Max; i++) begin
      ctrl[i].clear     = is_pat || last;
      ctrl[i].shift     = is_text;
      ctrl[i].wr_en     = wr_any && (wr_idx == IB'(i));
      ctrl[i].char_byte = in_data_i.char_byte;
    end
  end

  for (genvar g = 0; g < Max; g++) begin : g_cell
    if (g == 0) begin : g_head
      soc_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl[g]),
        .prev_match_i (1'b1),
        .match_o      (flag[g]),
        .hit_o        (hit[g])
      );
    end else begin : g_body
      soc_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl[g]),
        .prev_match_i (flag[g-1]),
        .match_o      (flag[g]),
        .hit_o        (hit[g])
      );
    end
  end

  always_comb begin
    seen_d      = seen_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (is_pat || last) begin
      seen_d  = '0;
      count_d = '0;
    end else if (is_text) begin
      seen_d  = seen_inc;
      count_d = count_inc;
    end
    if (last) begin
      out_valid_d = 1'b1;
      if (len_q == '0) begin
        out_data_d.status      = soc_pkg::StatusNoPattern;
        out_data_d.match_count = '0;
      end else if (seen_inc < len_q) begin
        out_data_d.status      = soc_pkg::StatusShort;
        out_data_d.match_count = '0;
      end else begin
        out_data_d.status      = soc_pkg::StatusOk;
        out_data_d.match_count = count_out;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      seen_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      seen_q      <= seen_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/soc_checker.sv =====
// port-level checks of the substring occurrence counter, bound to the top level
// depends on soc_pkg and substring_occurrence_counter_core
module soc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input soc_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input soc_pkg::out_item_t out_data_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // last text byte gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.cmd == soc_pkg::CmdText) && in_data_i.end_of_text |=> out_valid_o)
    else $error("missing result after end of text");

  // a pattern transaction never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_acc && (in_data_i.cmd != soc_pkg::CmdText) |=> !out_valid_o)
    else $error("result without end of text");

  // error status carries a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != soc_pkg::StatusOk) |-> out_data_o.match_count == '0)
    else $error("nonzero count with error status");

endmodule

bind substring_occurrence_counter_core soc_checker u_soc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
